/* rtl/core/eit_pkg.sv */
package eit_pkg;

   // Default table size.
   localparam int unsigned ENTRY_COUNT_DEF = 128;

   // Field widths of the request and response words.
   localparam int unsigned REQ_TYPE_W = 3;
   localparam int unsigned FD_W       = 12;
   localparam int unsigned FILE_W     = 16;
   localparam int unsigned MASK_W     = 32;
   localparam int unsigned USER_W     = 64;
   localparam int unsigned MAXEV_W    = 7;
   localparam int unsigned STATUS_W   = 3;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_ADD     = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_MODIFY  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_STATUS  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_COLLECT = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STS_INVALID = 3'd1;
   localparam logic [STATUS_W-1:0] STS_EXISTS  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_NOENT   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NOSPACE = 3'd4;

   // Event mask bits.
   localparam logic [MASK_W-1:0] ONE_SHOT_BIT = 32'h4000_0000;
   localparam logic [MASK_W-1:0] EDGE_BIT     = 32'h8000_0000;
   localparam logic [MASK_W-1:0] ERR_BIT      = 32'h0000_0008;
   localparam logic [MASK_W-1:0] HUP_BIT      = 32'h0000_0010;
   localparam logic [MASK_W-1:0] RDHUP_BIT    = 32'h0000_2000;

   // Most reports that one collect may give.
   localparam logic [MAXEV_W-1:0] COLLECT_LIMIT = 7'd64;

   // One interest entry as held in the slot memory.
   typedef struct packed {
      logic [FD_W-1:0]   fd;
      logic [FILE_W-1:0] file;
      logic [MASK_W-1:0] mask;
      logic [USER_W-1:0] user;
      logic [MASK_W-1:0] status;
   } entry_type;

endpackage

/* rtl/core/eit_req_if.sv */
interface eit_req_if;
   import eit_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [FD_W-1:0]       fd_number;
   logic [FILE_W-1:0]     file_id;
   logic [MASK_W-1:0]     event_mask;
   logic [USER_W-1:0]     user_word;
   logic [MAXEV_W-1:0]    max_events;

   modport source (
      output valid, req_type, fd_number, file_id, event_mask, user_word, max_events,
      input  ready
   );

   modport sink (
      input  valid, req_type, fd_number, file_id, event_mask, user_word, max_events,
      output ready
   );

endinterface

/* rtl/core/eit_rsp_if.sv */
interface eit_rsp_if;
   import eit_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status_code;
   logic                is_event;
   logic [MASK_W-1:0]   ready_events;
   logic [USER_W-1:0]   user_out;
   logic                last_result;

   modport source (
      output valid, status_code, is_event, ready_events, user_out, last_result,
      input  ready
   );

   modport sink (
      input  valid, status_code, is_event, ready_events, user_out, last_result,
      output ready
   );

endinterface

/* rtl/core/event_interest_table.sv */
// Event interest table.
// Requests arrive on req_chan (add, modify, delete, status update, collect) and
// each gives one or more response words on rsp_chan; last_result marks the final
// word of a request. Both channels move a word when valid and ready are high.
// Every request that is not rejected walks the slot memory once, one entry per
// cycle through its single read port while no stall pauses the walk. A rejected
// request goes straight from acceptance to its final word without a walk, and a
// collect ends early once it reaches its report limit.
// One request is handled at a time; the next is accepted while the last word
// of the previous one still waits in the response register.
// A collect holds one report back until it knows whether another follows; when
// the receiver stalls and a second report is due, the walk pauses.
// Reset clears the active and disarmed bits of every slot, so the table is empty
// and usable in the first cycle after reset; the slot memory itself is not swept.
module event_interest_table #(
   parameter int unsigned ENTRY_COUNT = eit_pkg::ENTRY_COUNT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   eit_req_if.sink   req_chan,
   eit_rsp_if.source rsp_chan
);
   import eit_pkg::*;

   localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRY_COUNT - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Slot memory and its registered read data.
   entry_type slot_mem_ff [ENTRY_COUNT];
   entry_type rd_data_ff;
   logic            rd_en;
   logic            mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type       mem_wdata;

   // Per-slot flags.
   logic [ENTRY_COUNT-1:0] active_ff, active_in;
   logic [ENTRY_COUNT-1:0] disarmed_ff, disarmed_in;

   // Sequencer state.
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_more_ff, rd_more_in;
   logic             eval_valid_ff, eval_valid_in;
   logic [IDX_W-1:0] eval_idx_ff, eval_idx_in;
   logic             eval_last_ff, eval_last_in;
   logic             hit_ff, hit_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [MAXEV_W-1:0] count_ff, count_in;
   logic             invalid_ff, invalid_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Latched request.
   logic [REQ_TYPE_W-1:0] op_type_ff, op_type_in;
   logic [FD_W-1:0]       op_fd_ff, op_fd_in;
   logic [FILE_W-1:0]     op_file_ff, op_file_in;
   logic [MASK_W-1:0]     op_mask_ff, op_mask_in;
   logic [USER_W-1:0]     op_user_ff, op_user_in;
   logic [MAXEV_W-1:0]    limit_ff, limit_in;

   // Held-back report and response register.
   logic [MASK_W-1:0]   pend_events_ff, pend_events_in;
   logic [USER_W-1:0]   pend_user_ff, pend_user_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_event_ff, rsp_event_in;
   logic [MASK_W-1:0]   rsp_events_ff, rsp_events_in;
   logic [USER_W-1:0]   rsp_user_ff, rsp_user_in;
   logic                rsp_last_ff, rsp_last_in;

   // Evaluation of the entry held in the registered read data.
   logic              out_free;
   logic              ev_active;
   logic              ev_disarmed;
   logic              key_hit;
   logic              file_hit;
   logic [MASK_W-1:0] wanted;
   logic [MASK_W-1:0] got;
   logic              report;
   logic              stall;
   logic [MAXEV_W-1:0] count_inc;
   logic [STATUS_W-1:0] final_status;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign ev_active   = active_ff[eval_idx_ff];
   assign ev_disarmed = disarmed_ff[eval_idx_ff];
   assign key_hit  = ev_active && (rd_data_ff.fd == op_fd_ff) && (rd_data_ff.file == op_file_ff);
   assign file_hit = ev_active && (rd_data_ff.file == op_file_ff);
   assign wanted   = (rd_data_ff.mask & ~(EDGE_BIT | ONE_SHOT_BIT))
                     | ERR_BIT | HUP_BIT | RDHUP_BIT;
   assign got      = rd_data_ff.status & wanted;
   assign report   = eval_valid_ff && (op_type_ff == REQ_COLLECT) && ev_active
                     && !ev_disarmed && (got != '0);
   assign stall    = report && pend_valid_ff && !out_free;
   assign count_inc = count_ff + MAXEV_W'(1);

   // Status of the single response word that closes a request.
   always_comb begin
      if (invalid_ff) begin
         final_status = STS_INVALID;
      end else if (op_type_ff == REQ_ADD) begin
         if (hit_ff) begin
            final_status = STS_EXISTS;
         end else if (free_found_ff) begin
            final_status = STS_OK;
         end else begin
            final_status = STS_NOSPACE;
         end
      end else if (op_type_ff == REQ_COLLECT) begin
         final_status = STS_OK;
      end else begin
         final_status = hit_ff ? STS_OK : STS_NOENT;
      end
   end

   // Sequencer: accept, walk the slots unless the request is rejected, then close the request.
   always_comb begin
      state_in       = state_ff;
      rd_idx_in      = rd_idx_ff;
      rd_more_in     = rd_more_ff;
      eval_valid_in  = eval_valid_ff;
      eval_idx_in    = eval_idx_ff;
      eval_last_in   = eval_last_ff;
      hit_in         = hit_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      count_in       = count_ff;
      invalid_in     = invalid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_events_in = pend_events_ff;
      pend_user_in   = pend_user_ff;
      op_type_in     = op_type_ff;
      op_fd_in       = op_fd_ff;
      op_file_in     = op_file_ff;
      op_mask_in     = op_mask_ff;
      op_user_in     = op_user_ff;
      limit_in       = limit_ff;
      active_in      = active_ff;
      disarmed_in    = disarmed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_events_in  = rsp_events_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = eval_idx_ff;
      mem_wdata      = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_type_in    = req_chan.req_type;
               op_fd_in      = req_chan.fd_number;
               op_file_in    = req_chan.file_id;
               op_mask_in    = req_chan.event_mask;
               op_user_in    = req_chan.user_word;
               limit_in      = (req_chan.max_events > COLLECT_LIMIT) ? COLLECT_LIMIT
                                                                    : req_chan.max_events;
               invalid_in    = (req_chan.req_type > REQ_COLLECT)
                               || ((req_chan.req_type == REQ_COLLECT)
                                   && (req_chan.max_events == '0))
                               || ((req_chan.req_type != REQ_COLLECT)
                                   && (req_chan.file_id == '0));
               rd_idx_in     = '0;
               rd_more_in    = 1'b1;
               eval_valid_in = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               count_in      = '0;
               pend_valid_in = 1'b0;
               state_in      = invalid_in ? ST_FINISH : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               // Issue the next read.
               rd_en         = rd_more_ff;
               eval_valid_in = rd_more_ff;
               eval_idx_in   = rd_idx_ff;
               eval_last_in  = (rd_idx_ff == LAST_IDX);
               rd_idx_in     = rd_idx_ff + IDX_W'(1);
               rd_more_in    = (rd_idx_ff != LAST_IDX);

               // Act on the entry fetched by the last issued read.
               if (eval_valid_ff) begin
                  if (op_type_ff == REQ_ADD) begin
                     if (key_hit) begin
                        hit_in = 1'b1;
                     end
                     if (!ev_active && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = eval_idx_ff;
                     end
                  end else if (op_type_ff == REQ_MODIFY) begin
                     if (key_hit) begin
                        hit_in                   = 1'b1;
                        mem_we                   = 1'b1;
                        mem_wdata.mask           = op_mask_ff;
                        mem_wdata.user           = op_user_ff;
                        disarmed_in[eval_idx_ff] = 1'b0;
                     end
                  end else if (op_type_ff == REQ_DELETE) begin
                     if (key_hit) begin
                        hit_in                   = 1'b1;
                        active_in[eval_idx_ff]   = 1'b0;
                        disarmed_in[eval_idx_ff] = 1'b0;
                     end
                  end else if (op_type_ff == REQ_STATUS) begin
                     if (file_hit) begin
                        hit_in           = 1'b1;
                        mem_we           = 1'b1;
                        mem_wdata.status = op_mask_ff;
                     end
                  end

                  if (report) begin
                     // The held-back report goes out; the new one is held.
                     if (pend_valid_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_OK;
                        rsp_event_in  = 1'b1;
                        rsp_events_in = pend_events_ff;
                        rsp_user_in   = pend_user_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pend_valid_in  = 1'b1;
                     pend_events_in = got;
                     pend_user_in   = rd_data_ff.user;
                     count_in       = count_inc;
                     if ((rd_data_ff.mask & ONE_SHOT_BIT) != '0) begin
                        disarmed_in[eval_idx_ff] = 1'b1;
                     end
                  end

                  if (eval_last_ff || (report && (count_inc == limit_ff))) begin
                     state_in      = ST_FINISH;
                     eval_valid_in = 1'b0;
                     rd_en         = 1'b0;
                  end
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (!invalid_ff && (op_type_ff == REQ_COLLECT) && pend_valid_ff) begin
                  rsp_status_in = STS_OK;
                  rsp_event_in  = 1'b1;
                  rsp_events_in = pend_events_ff;
                  rsp_user_in   = pend_user_ff;
               end else begin
                  rsp_status_in = final_status;
                  rsp_event_in  = 1'b0;
                  rsp_events_in = '0;
                  rsp_user_in   = '0;
               end
               // Commit an add into the lowest free slot.
               if (!invalid_ff && (op_type_ff == REQ_ADD) && !hit_ff && free_found_ff) begin
                  mem_we                   = 1'b1;
                  mem_waddr                = free_idx_ff;
                  mem_wdata.fd             = op_fd_ff;
                  mem_wdata.file           = op_file_ff;
                  mem_wdata.mask           = op_mask_ff;
                  mem_wdata.user           = op_user_ff;
                  mem_wdata.status         = '0;
                  active_in[free_idx_ff]   = 1'b1;
                  disarmed_in[free_idx_ff] = 1'b0;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         rd_more_ff    <= 1'b0;
         eval_valid_ff <= 1'b0;
         eval_idx_ff   <= '0;
         eval_last_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         count_ff      <= '0;
         invalid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= '0;
         disarmed_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         rd_more_ff    <= rd_more_in;
         eval_valid_ff <= eval_valid_in;
         eval_idx_ff   <= eval_idx_in;
         eval_last_ff  <= eval_last_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
         count_ff      <= count_in;
         invalid_ff    <= invalid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         active_ff     <= active_in;
         disarmed_ff   <= disarmed_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_type_ff     <= op_type_in;
      op_fd_ff       <= op_fd_in;
      op_file_ff     <= op_file_in;
      op_mask_ff     <= op_mask_in;
      op_user_ff     <= op_user_in;
      limit_ff       <= limit_in;
      pend_events_ff <= pend_events_in;
      pend_user_ff   <= pend_user_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_event_ff   <= rsp_event_in;
      rsp_events_ff  <= rsp_events_in;
      rsp_user_ff    <= rsp_user_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem_ff[rd_idx_ff];
      end
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status_code  = rsp_status_ff;
   assign rsp_chan.is_event     = rsp_event_ff;
   assign rsp_chan.ready_events = rsp_events_ff;
   assign rsp_chan.user_out     = rsp_user_ff;
   assign rsp_chan.last_result  = rsp_last_ff;

endmodule
